// ----- src/fvba_pkg.sv -----
// Shared types and constants for the frustum volume box accumulator.
// No dependencies; every other file in src imports this package.
`default_nettype none
package fvba_pkg;

    localparam int COORD_BITS_DEF = 20;
    localparam int VOL_BITS       = 63;
    localparam int QUEUE_DEPTH    = 2;
    localparam int MUL_BITS       = 33;
    localparam int WIDE_BITS      = 64;
    localparam int ADDR_BITS      = 6;
    localparam int DATA_BITS      = 64;

    localparam logic [VOL_BITS-1:0] SUM_MAX  = {VOL_BITS{1'b1}};
    // round(pi/3 * 2^32), split into integer one and fraction
    localparam logic [32:0]         PI3_K    = 33'd4497679235;
    localparam logic [27:0]         PI3_FRAC = 28'd202711939;

    typedef enum logic [2:0] {
        REG_STRIDE    = 3'd0,
        REG_SMALL_MIN = 3'd1,
        REG_SMALL_MAX = 3'd2,
        REG_BIG_MIN   = 3'd3,
        REG_BIG_MAX   = 3'd4
    } t_reg_idx;

    typedef enum logic [4:0] {
        B_IDLE, B_SQX, B_SQY, B_SQZ, B_SQW, B_ROOT,
        B_SRR, B_SPP, B_SRP, B_SW, B_PLO, B_PHI, B_PW,
        B_KHI, B_KLO, B_KW, B_SUM
    } t_bstate;

    typedef struct packed {
        logic pass_start;
        logic seg;
        logic over_small;
        logic over_big;
    } t_ctl;

endpackage
`default_nettype wire

// ----- src/fvba_front.sv -----
// Front end: accepts spheres, tracks stride and the last kept sphere,
// tests box overlap and emits one command per item. Uses fvba_pkg.
`default_nettype none
module fvba_front #(
    parameter int COORD_BITS = fvba_pkg::COORD_BITS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_ready,
    input  wire  [COORD_BITS-1:0]      i_center_x,
    input  wire  [COORD_BITS-1:0]      i_center_y,
    input  wire  [COORD_BITS-1:0]      i_center_z,
    input  wire  [COORD_BITS-2:0]      i_sphere_radius,
    input  wire                        i_branch_start,
    input  wire                        i_pass_start,
    input  wire  [7:0]                 i_stride,
    input  wire  [3*COORD_BITS-1:0]    i_small_min,
    input  wire  [3*COORD_BITS-1:0]    i_small_max,
    input  wire  [3*COORD_BITS-1:0]    i_big_min,
    input  wire  [3*COORD_BITS-1:0]    i_big_max,
    input  wire                        i_full,
    output logic                       o_push,
    output fvba_pkg::t_ctl             o_ctl,
    output logic [COORD_BITS-1:0]      o_adx,
    output logic [COORD_BITS-1:0]      o_ady,
    output logic [COORD_BITS-1:0]      o_adz,
    output logic [COORD_BITS-2:0]      o_radius,
    output logic [COORD_BITS-2:0]      o_prev_radius
);
    import fvba_pkg::*;

    localparam int C = COORD_BITS;

    logic [C-1:0]        r_px, r_py, r_pz;
    logic [C-2:0]        r_pr;
    logic [7:0]          r_count;

    logic [7:0]          eff;
    logic [8:0]          nxt;
    logic                keep;
    logic signed [C:0]   ctr [3];
    logic signed [C:0]   prv [3];
    logic signed [C:0]   dif [3];
    logic [C-1:0]        adif [3];
    logic signed [C:0]   rad_ext;
    logic signed [C:0]   lo_s, hi_s, lo_b, hi_b;
    logic                hit_s, hit_b;
    logic                accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;

    always_comb begin
        eff     = (i_stride == 8'd0) ? 8'd1 : i_stride;
        nxt     = {1'b0, r_count} + 9'd1;
        keep    = nxt >= {1'b0, eff};
        ctr[0]  = {i_center_x[C-1], i_center_x};
        ctr[1]  = {i_center_y[C-1], i_center_y};
        ctr[2]  = {i_center_z[C-1], i_center_z};
        prv[0]  = {r_px[C-1], r_px};
        prv[1]  = {r_py[C-1], r_py};
        prv[2]  = {r_pz[C-1], r_pz};
        rad_ext = {2'b00, i_sphere_radius};
        hit_s   = 1'b1;
        hit_b   = 1'b1;
        lo_s    = '0;
        hi_s    = '0;
        lo_b    = '0;
        hi_b    = '0;
        for (int k = 0; k < 3; k++) begin
            dif[k]  = ctr[k] - prv[k];
            adif[k] = dif[k][C] ? C'(-dif[k]) : dif[k][C-1:0];
            lo_s = {i_small_min[k*C+C-1], i_small_min[k*C +: C]};
            hi_s = {i_small_max[k*C+C-1], i_small_max[k*C +: C]};
            lo_b = {i_big_min[k*C+C-1], i_big_min[k*C +: C]};
            hi_b = {i_big_max[k*C+C-1], i_big_max[k*C +: C]};
            // touching counts as overlap
            if ((ctr[k] + rad_ext < lo_s) || (ctr[k] - rad_ext > hi_s)) begin
                hit_s = 1'b0;
            end
            if ((ctr[k] + rad_ext < lo_b) || (ctr[k] - rad_ext > hi_b)) begin
                hit_b = 1'b0;
            end
        end
        o_ctl.pass_start = i_pass_start;
        o_ctl.seg        = !i_branch_start && keep;
        o_ctl.over_small = o_ctl.seg && hit_s;
        o_ctl.over_big   = o_ctl.seg && hit_b;
        o_adx            = adif[0];
        o_ady            = adif[1];
        o_adz            = adif[2];
        o_radius         = i_sphere_radius;
        o_prev_radius    = r_pr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px    <= '0;
            r_py    <= '0;
            r_pz    <= '0;
            r_pr    <= '0;
            r_count <= '0;
        end else if (accept) begin
            if (i_branch_start || keep) begin
                r_px    <= i_center_x;
                r_py    <= i_center_y;
                r_pz    <= i_center_z;
                r_pr    <= i_sphere_radius;
                r_count <= '0;
            end else begin
                r_count <= nxt[7:0];
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/fvba_queue.sv -----
// Small register FIFO between the front end and the arithmetic back end.
// Uses fvba_pkg for its default depth.
`default_nettype none
module fvba_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = fvba_pkg::QUEUE_DEPTH
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire  [WIDTH-1:0] i_data,
    input  wire              i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    import fvba_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;

    assign o_data  = r_mem[r_rp];
    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_empty = r_cnt == '0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != '0) else $error("queue popped while empty");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_cnt != CW'(DEPTH)) else $error("queue pushed while full");

endmodule
`default_nettype wire

// ----- src/fvba_back.sv -----
// Back end: per segment command, squared distance, bit-serial square root,
// radius sum, product and pi/3 scaling on one shared multiplier, then the
// saturating box sums and the result register. Uses fvba_pkg.
`default_nettype none
module fvba_back #(
    parameter int COORD_BITS = fvba_pkg::COORD_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_empty,
    output logic                         o_pop,
    input  fvba_pkg::t_ctl               i_ctl,
    input  wire  [COORD_BITS-1:0]        i_adx,
    input  wire  [COORD_BITS-1:0]        i_ady,
    input  wire  [COORD_BITS-1:0]        i_adz,
    input  wire  [COORD_BITS-2:0]        i_radius,
    input  wire  [COORD_BITS-2:0]        i_prev_radius,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [fvba_pkg::VOL_BITS-1:0] o_volume_small,
    output logic [fvba_pkg::VOL_BITS-1:0] o_vol_big,
    output logic                         o_added_small,
    output logic                         o_added_big
);
    import fvba_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int NW = $clog2(C + 1);

    t_bstate              r_state, n_state;
    t_ctl                 r_ctl;
    logic [C-1:0]         r_adx, r_ady, r_adz;
    logic [C-2:0]         r_ra, r_rb;
    logic [2*MUL_BITS-1:0] r_prod;
    logic [WIDE_BITS-1:0] r_acc, r_p, r_vol;
    logic [2*C+1:0]       r_rad;
    logic [C+1:0]         r_rem;
    logic [C:0]           r_root;
    logic [NW-1:0]        r_cnt;
    logic [2*C-1:0]       r_s;
    logic [VOL_BITS-1:0]  r_sum_small, r_sum_big;
    logic                 r_out_valid;

    logic [MUL_BITS-1:0]  mul_a, mul_b;
    logic                 load;
    logic [C+3:0]         rem_sh, trial, rem_dif;
    logic [WIDE_BITS-1:0] acc_add;
    logic [VOL_BITS:0]    sum_s, sum_b;

    assign o_valid = r_out_valid;
    assign acc_add = r_acc + r_prod[WIDE_BITS-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    n_state = i_ctl.seg ? B_SQX : B_SUM;
                end
            end
            B_SQX:  n_state = B_SQY;
            B_SQY:  n_state = B_SQZ;
            B_SQZ:  n_state = B_SQW;
            B_SQW:  n_state = B_ROOT;
            B_ROOT: n_state = (r_cnt == NW'(C)) ? B_SRR : B_ROOT;
            B_SRR:  n_state = B_SPP;
            B_SPP:  n_state = B_SRP;
            B_SRP:  n_state = B_SW;
            B_SW:   n_state = B_PLO;
            B_PLO:  n_state = B_PHI;
            B_PHI:  n_state = B_PW;
            B_PW:   n_state = B_KHI;
            B_KHI:  n_state = B_KLO;
            B_KLO:  n_state = B_KW;
            B_KW:   n_state = B_SUM;
            B_SUM:  n_state = load ? B_IDLE : B_SUM;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop = 1'b0;
        load  = 1'b0;
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            B_IDLE: o_pop = !i_empty;
            B_SQX: begin
                mul_a = MUL_BITS'(r_adx);
                mul_b = MUL_BITS'(r_adx);
            end
            B_SQY: begin
                mul_a = MUL_BITS'(r_ady);
                mul_b = MUL_BITS'(r_ady);
            end
            B_SQZ: begin
                mul_a = MUL_BITS'(r_adz);
                mul_b = MUL_BITS'(r_adz);
            end
            B_SRR: begin
                mul_a = MUL_BITS'(r_ra);
                mul_b = MUL_BITS'(r_ra);
            end
            B_SPP: begin
                mul_a = MUL_BITS'(r_rb);
                mul_b = MUL_BITS'(r_rb);
            end
            B_SRP: begin
                mul_a = MUL_BITS'(r_ra);
                mul_b = MUL_BITS'(r_rb);
            end
            B_PLO: begin
                mul_a = MUL_BITS'(r_root);
                mul_b = MUL_BITS'(r_s[C-1:0]);
            end
            B_PHI: begin
                mul_a = MUL_BITS'(r_root);
                mul_b = MUL_BITS'(r_s[2*C-1:C]);
            end
            B_KHI: begin
                mul_a = MUL_BITS'(r_p[63:32]);
                mul_b = PI3_K;
            end
            B_KLO: begin
                mul_a = MUL_BITS'(r_p[31:0]);
                mul_b = MUL_BITS'(PI3_FRAC);
            end
            B_SUM: load = !r_out_valid || i_ready;
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // one root digit per cycle
    always_comb begin
        rem_sh  = {r_rem, r_rad[2*C+1:2*C]};
        trial   = {1'b0, r_root, 2'b01};
        rem_dif = rem_sh - trial;
    end

    always_comb begin
        sum_s = {1'b0, r_sum_small} + r_vol[VOL_BITS:0];
        sum_b = {1'b0, r_sum_big} + r_vol[VOL_BITS:0];
        if (r_vol[WIDE_BITS-1] || sum_s > {1'b0, SUM_MAX}) begin
            sum_s = {1'b0, SUM_MAX};
        end
        if (r_vol[WIDE_BITS-1] || sum_b > {1'b0, SUM_MAX}) begin
            sum_b = {1'b0, SUM_MAX};
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            B_IDLE: begin
                r_ctl <= i_ctl;
                r_adx <= i_adx;
                r_ady <= i_ady;
                r_adz <= i_adz;
                r_ra  <= i_radius;
                r_rb  <= i_prev_radius;
            end
            B_SQX: r_acc <= '0;
            B_SQY: r_acc <= acc_add;
            B_SQZ: r_acc <= acc_add;
            B_SQW: begin
                r_rad  <= acc_add[2*C+1:0];
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end
            B_ROOT: begin
                r_rad <= r_rad << 2;
                r_cnt <= r_cnt + 1'b1;
                if (rem_sh >= trial) begin
                    r_rem  <= rem_dif[C+1:0];
                    r_root <= {r_root[C-1:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh[C+1:0];
                    r_root <= {r_root[C-1:0], 1'b0};
                end
            end
            B_SRR: r_acc <= '0;
            B_SPP: r_acc <= acc_add;
            B_SRP: r_acc <= acc_add;
            B_SW:  r_s   <= acc_add[2*C-1:0];
            B_PHI: r_acc <= r_prod[WIDE_BITS-1:0];
            B_PW:  r_p   <= r_acc + (r_prod[WIDE_BITS-1:0] << C);
            B_KLO: r_acc <= r_prod[WIDE_BITS-1:0];
            B_KW:  r_vol <= r_acc + {32'b0, r_prod[63:32]} + {32'b0, r_p[31:0]};
            default: begin
                r_acc <= r_acc;
            end
        endcase
        if (load) begin
            o_volume_small <= (r_ctl.over_small) ? sum_s[VOL_BITS-1:0] : r_sum_small;
            o_vol_big      <= (r_ctl.over_big) ? sum_b[VOL_BITS-1:0] : r_sum_big;
            o_added_small  <= r_ctl.over_small;
            o_added_big    <= r_ctl.over_big;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_sum_small <= '0;
            r_sum_big   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop && i_ctl.pass_start) begin
                r_sum_small <= '0;
                r_sum_big   <= '0;
            end else if (load) begin
                if (r_ctl.over_small) begin
                    r_sum_small <= sum_s[VOL_BITS-1:0];
                end
                if (r_ctl.over_big) begin
                    r_sum_big <= sum_b[VOL_BITS-1:0];
                end
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_root_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_ROOT |-> r_cnt <= NW'(C)) else $error("root ran past its digits");
    a_pass_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_ctl.pass_start) |=> (r_sum_small == '0 && r_sum_big == '0))
        else $error("pass start did not clear sums");
    a_no_seg_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !r_ctl.seg) |=> (!o_added_small && !o_added_big))
        else $error("added flag without a segment");

endmodule
`default_nettype wire

// ----- src/frustum_volume_box_accumulator_unit.sv -----
// Frustum volume box accumulator. One result per sphere, in order. A sphere that
// closes a segment runs the whole back end: the bit-serial square root produces
// one result bit per cycle and the shared multiplier handles the squares, radius
// sum, product and pi/3 scaling one a cycle. Other spheres go straight to the
// result register. A two-entry queue lets the front keep accepting.
// Registers sit on the APB port at 8-byte spacing. Depends on fvba_pkg.
`default_nettype none
module frustum_volume_box_accumulator_unit #(
    parameter int COORD_BITS = fvba_pkg::COORD_BITS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_ready,
    input  wire  [COORD_BITS-1:0]         i_center_x,
    input  wire  [COORD_BITS-1:0]         i_center_y,
    input  wire  [COORD_BITS-1:0]         i_center_z,
    input  wire  [COORD_BITS-2:0]         i_sphere_radius,
    input  wire                           i_branch_start,
    input  wire                           i_pass_start,
    output logic                          o_valid,
    input  wire                           i_ready,
    output logic [fvba_pkg::VOL_BITS-1:0] o_volume_small,
    output logic [fvba_pkg::VOL_BITS-1:0] o_vol_big,
    output logic                          o_added_small,
    output logic                          o_added_big,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [fvba_pkg::ADDR_BITS-1:0] paddr,
    input  wire  [fvba_pkg::DATA_BITS-1:0] pwdata,
    output logic [fvba_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready
);
    import fvba_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int BW = 3 * C;
    localparam int QW = $bits(t_ctl) + 3 * C + 2 * (C - 1);

    logic [7:0]    r_stride;
    logic [BW-1:0] r_small_min, r_small_max, r_big_min, r_big_max;
    logic          wr;
    t_reg_idx      idx;

    t_ctl          f_ctl, q_ctl;
    logic          push, pop, full, empty;
    logic [C-1:0]  f_adx, f_ady, f_adz, q_adx, q_ady, q_adz;
    logic [C-2:0]  f_r, f_pr, q_r, q_pr;
    logic [QW-1:0] q_in, q_out;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[5:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride    <= 8'd1;
            r_small_min <= '0;
            r_small_max <= '0;
            r_big_min   <= '0;
            r_big_max   <= '0;
        end else if (wr) begin
            case (idx)
                REG_STRIDE:    r_stride    <= pwdata[7:0];
                REG_SMALL_MIN: r_small_min <= pwdata[BW-1:0];
                REG_SMALL_MAX: r_small_max <= pwdata[BW-1:0];
                REG_BIG_MIN:   r_big_min   <= pwdata[BW-1:0];
                REG_BIG_MAX:   r_big_max   <= pwdata[BW-1:0];
                default:       r_stride    <= r_stride;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_STRIDE:    prdata = DATA_BITS'(r_stride);
            REG_SMALL_MIN: prdata = DATA_BITS'(r_small_min);
            REG_SMALL_MAX: prdata = DATA_BITS'(r_small_max);
            REG_BIG_MIN:   prdata = DATA_BITS'(r_big_min);
            REG_BIG_MAX:   prdata = DATA_BITS'(r_big_max);
            default:       prdata = '0;
        endcase
    end

    fvba_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_center_z     (i_center_z),
        .i_sphere_radius(i_sphere_radius),
        .i_branch_start (i_branch_start),
        .i_pass_start   (i_pass_start),
        .i_stride       (r_stride),
        .i_small_min    (r_small_min),
        .i_small_max    (r_small_max),
        .i_big_min      (r_big_min),
        .i_big_max      (r_big_max),
        .i_full         (full),
        .o_push         (push),
        .o_ctl          (f_ctl),
        .o_adx          (f_adx),
        .o_ady          (f_ady),
        .o_adz          (f_adz),
        .o_radius       (f_r),
        .o_prev_radius  (f_pr)
    );

    assign q_in = {f_ctl, f_adx, f_ady, f_adz, f_r, f_pr};
    assign {q_ctl, q_adx, q_ady, q_adz, q_r, q_pr} = q_out;

    fvba_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_full  (full),
        .o_empty (empty)
    );

    fvba_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .o_pop          (pop),
        .i_ctl          (q_ctl),
        .i_adx          (q_adx),
        .i_ady          (q_ady),
        .i_adz          (q_adz),
        .i_radius       (q_r),
        .i_prev_radius  (q_pr),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_volume_small (o_volume_small),
        .o_vol_big      (o_vol_big),
        .o_added_small  (o_added_small),
        .o_added_big    (o_added_big)
    );

endmodule
`default_nettype wire

// ----- bench/tb_frustum_volume_box_accumulator_unit.sv -----
// Testbench for frustum_volume_box_accumulator_unit: directed table, then random spheres
// in several register settings, checked against an in-bench volume predictor or table values.
// Depends on fvba_pkg and the unit under test only.
`timescale 1ns / 100ps
module tb_frustum_volume_box_accumulator_unit;
    import fvba_pkg::*;

    localparam int CB         = 20;
    localparam int WDOG_LIMIT = 5000;
    localparam int DRAIN      = 60;

    typedef struct {
        logic [CB-1:0] x, y, z;
        logic [CB-2:0] r;
        logic          bstart, pstart;
        bit            known;
        logic [VOL_BITS-1:0] vs, vb;
        logic          as, ab;
    } t_row;

    typedef struct {
        logic [VOL_BITS-1:0] vs, vb;
        logic                as, ab;
    } t_vol_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [CB-1:0] i_center_x = '0, i_center_y = '0, i_center_z = '0;
    logic [CB-2:0] i_sphere_radius = '0;
    logic i_branch_start = 1'b0, i_pass_start = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [VOL_BITS-1:0] o_volume_small, o_vol_big;
    logic o_added_small, o_added_big;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [DATA_BITS-1:0] pwdata = '0;
    logic [DATA_BITS-1:0] prdata;
    logic pready;

    frustum_volume_box_accumulator_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_center_x(i_center_x), .i_center_y(i_center_y), .i_center_z(i_center_z),
        .i_sphere_radius(i_sphere_radius), .i_branch_start(i_branch_start),
        .i_pass_start(i_pass_start), .o_valid(o_valid), .i_ready(i_ready),
        .o_volume_small(o_volume_small), .o_vol_big(o_vol_big),
        .o_added_small(o_added_small), .o_added_big(o_added_big),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // predictor copy of registers and state
    logic [7:0]  cfg_stride = 8'd1;
    logic [59:0] cfg_smin = '0, cfg_smax = '0, cfg_bmin = '0, cfg_bmax = '0;
    longint      kept_x = 0, kept_y = 0, kept_z = 0;
    longint unsigned kept_r = 0;
    longint unsigned gap_count = 0;
    logic [VOL_BITS-1:0] acc_small = '0, acc_big = '0;

    t_vol_result expected_vols[$];
    int  err_count = 0;
    int  item_count = 0, segment_count = 0, sat_count = 0;
    bit  no_idle = 0;
    int  stall_left = 0;
    int  idle_cycles = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned res = 0;
        longint unsigned bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic bit cube_hits(input longint c[3], input longint r,
                                     input logic [59:0] bmin, input logic [59:0] bmax);
        longint lo, hi;
        for (int i = 0; i < 3; i++) begin
            lo = $signed(bmin[CB*i +: CB]);
            hi = $signed(bmax[CB*i +: CB]);
            if (c[i] + r < lo || c[i] - r > hi) return 0;
        end
        return 1;
    endfunction

    function automatic logic [VOL_BITS-1:0] add_clamped(input logic [VOL_BITS-1:0] a,
                                                       input longint unsigned b);
        longint unsigned s = 64'(a) + b;
        if (s > 64'(SUM_MAX)) begin
            sat_count++;
            return SUM_MAX;
        end
        return s[VOL_BITS-1:0];
    endfunction

    // advance predicted state by one sphere, return the sums it should report
    function automatic t_vol_result predict_volumes(input t_row s);
        t_vol_result res;
        longint c[3];
        longint unsigned r, eff, d, sq, p, ph, pl, vol, k, frac;
        longint dx, dy, dz;
        c[0] = $signed(s.x);
        c[1] = $signed(s.y);
        c[2] = $signed(s.z);
        r = s.r;
        res.as = 0;
        res.ab = 0;
        if (s.pstart) begin
            acc_small = '0;
            acc_big = '0;
        end
        if (s.bstart) begin
            gap_count = 0;
            kept_x = c[0]; kept_y = c[1]; kept_z = c[2]; kept_r = r;
        end else begin
            eff = (cfg_stride == 0) ? 1 : cfg_stride;
            if (gap_count + 1 >= eff) begin
                dx = c[0] - kept_x;
                dy = c[1] - kept_y;
                dz = c[2] - kept_z;
                d = root_floor(dx * dx + dy * dy + dz * dz);
                sq = r * r + kept_r * kept_r + r * kept_r;
                p = d * sq;
                ph = p >> 32;
                pl = p & 64'hFFFF_FFFF;
                k = PI3_K;
                frac = PI3_FRAC;
                vol = ph * k + pl + ((pl * frac) >> 32);
                segment_count++;
                if (cube_hits(c, longint'(r), cfg_smin, cfg_smax)) begin
                    acc_small = add_clamped(acc_small, vol);
                    res.as = 1;
                end
                if (cube_hits(c, longint'(r), cfg_bmin, cfg_bmax)) begin
                    acc_big = add_clamped(acc_big, vol);
                    res.ab = 1;
                end
                kept_x = c[0]; kept_y = c[1]; kept_z = c[2]; kept_r = r;
                gap_count = 0;
            end else begin
                gap_count = (gap_count + 1) & 64'hFF;
            end
        end
        res.vs = acc_small;
        res.vb = acc_big;
        return res;
    endfunction

    function automatic int pick_gap();
        int roll = $urandom_range(0, 99);
        if (no_idle || roll < 60) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [63:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_STRIDE:    cfg_stride = value[7:0];
            REG_SMALL_MIN: cfg_smin = value[59:0];
            REG_SMALL_MAX: cfg_smax = value[59:0];
            REG_BIG_MIN:   cfg_bmin = value[59:0];
            REG_BIG_MAX:   cfg_bmax = value[59:0];
            default: ;
        endcase
    endtask

    function automatic logic [63:0] pack_box(input int x, input int y, input int z);
        logic [CB-1:0] px = CB'(x), py = CB'(y), pz = CB'(z);
        return {4'b0, pz, py, px};
    endfunction

    task automatic apply_setting(input logic [7:0] stride, input logic [63:0] smin,
                                 input logic [63:0] smax, input logic [63:0] bmin,
                                 input logic [63:0] bmax);
        write_reg(REG_STRIDE, {56'b0, stride});
        write_reg(REG_SMALL_MIN, smin);
        write_reg(REG_SMALL_MAX, smax);
        write_reg(REG_BIG_MIN, bmin);
        write_reg(REG_BIG_MAX, bmax);
    endtask

    // hold the sender until every result is back, then let the back end settle
    task automatic drain_results();
        while (expected_vols.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic send_sphere(input t_row s, input bit last_in_burst);
        int gap = pick_gap();
        t_vol_result pred;
        i_valid <= 1'b1;
        i_center_x <= s.x;
        i_center_y <= s.y;
        i_center_z <= s.z;
        i_sphere_radius <= s.r;
        i_branch_start <= s.bstart;
        i_pass_start <= s.pstart;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pred = predict_volumes(s);
        if (s.known) begin
            pred.vs = s.vs; pred.vb = s.vb; pred.as = s.as; pred.ab = s.ab;
        end
        expected_vols.insert(expected_vols.size(), pred);
        item_count++;
        if (gap > 0 || last_in_burst) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [CB-1:0] rand_coord(input bit wide);
        int roll = $urandom_range(0, 99);
        if (wide || roll < 25) return CB'($urandom);
        if (roll < 35) return roll[0] ? 20'h7FFFF : 20'h80000;
        return CB'($urandom_range(0, 8191) - 4096);
    endfunction

    function automatic t_row rand_sphere(input bit wide, input int bs_odds);
        t_row s;
        int roll = $urandom_range(0, 99);
        s.x = rand_coord(wide);
        s.y = rand_coord(wide);
        s.z = rand_coord(wide);
        if (wide || roll < 15) s.r = (CB-1)'($urandom);
        else if (roll < 22) s.r = roll[0] ? '1 : '0;
        else s.r = (CB-1)'($urandom_range(0, 2047));
        s.bstart = ($urandom_range(1, bs_odds) == 1);
        s.pstart = ($urandom_range(1, 40) == 1);
        s.known = 0;
        return s;
    endfunction

    function automatic t_row mk_row(input int x, input int y, input int z, input int r,
                                    input bit bs, input bit ps);
        t_row s;
        s.x = CB'(x); s.y = CB'(y); s.z = CB'(z); s.r = (CB-1)'(r);
        s.bstart = bs; s.pstart = ps;
        s.known = 0;
        s.vs = '0; s.vb = '0; s.as = 0; s.ab = 0;
        return s;
    endfunction

    function automatic t_row mk_fixed(input t_row s, input bit as, input bit ab);
        s.known = 1;
        s.as = as;
        s.ab = ab;
        return s;
    endfunction

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_vols.size() == 0) begin
                report_mismatch("result with nothing expected", o_volume_small, 0);
            end else begin
                automatic t_vol_result e = expected_vols.pop_front();
                if (o_volume_small !== e.vs) report_mismatch("volume_small", o_volume_small, e.vs);
                if (o_vol_big !== e.vb) report_mismatch("vol_big", o_vol_big, e.vb);
                if (o_added_small !== e.as) report_mismatch("added_small", o_added_small, e.as);
                if (o_added_big !== e.ab) report_mismatch("added_big", o_added_big, e.ab);
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 99) < 12) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                       : $urandom_range(0, 2);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles", WDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_row dir[$];
        t_row s;
        int n_per;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: stride 1, both boxes are the single point at the origin
        dir.insert(dir.size(), mk_fixed(mk_row(0, 0, 0, 0, 0, 0), 1, 1));
        dir.insert(dir.size(), mk_fixed(mk_row(524287, 524287, 524287, 0, 1, 0), 0, 0));
        dir.insert(dir.size(),
                   mk_fixed(mk_row(-524288, -524288, -524288, 524287, 0, 0), 0, 0));
        dir.insert(dir.size(), mk_row(0, 0, 0, 256, 0, 0));
        dir.insert(dir.size(), mk_row(300, -300, 1000, 512, 0, 0));
        dir.insert(dir.size(), mk_row(-524288, 524287, 0, 524287, 0, 0));
        dir.insert(dir.size(), mk_row(524287, -524288, 0, 524287, 0, 0));
        dir.insert(dir.size(), mk_fixed(mk_row(5, 5, 5, 3, 1, 1), 0, 0));
        dir.insert(dir.size(), mk_row(0, 0, 1, 1, 0, 0));
        dir.insert(dir.size(), mk_row(0, 0, 0, 524287, 0, 1));
        dir.insert(dir.size(), mk_row(-1, -1, -1, 1, 0, 0));
        dir.insert(dir.size(), mk_row(1, 1, 1, 0, 0, 0));
        foreach (dir[i]) send_sphere(dir[i], i == dir.size() - 1);
        drain_results();

        // stride 4, two spheres into a branch, then lower stride mid-branch
        apply_setting(8'd4, pack_box(-4096, -4096, -4096), pack_box(4096, 4096, 4096),
                      pack_box(-524288, -524288, -524288), pack_box(524287, 524287, 524287));
        send_sphere(mk_row(100, 100, 100, 50, 1, 1), 0);
        send_sphere(mk_row(200, 100, 100, 60, 0, 0), 0);
        send_sphere(mk_row(300, 100, 100, 70, 0, 0), 1);
        drain_results();
        apply_setting(8'd1, pack_box(-4096, -4096, -4096), pack_box(4096, 4096, 4096),
                      pack_box(-524288, -524288, -524288), pack_box(524287, 524287, 524287));
        send_sphere(mk_row(400, 100, 100, 80, 0, 0), 0);
        send_sphere(mk_row(-500, 4000, 100, 90, 0, 0), 1);
        drain_results();

        n_per = 150;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: apply_setting(8'd1, pack_box(-2048, -2048, -2048), pack_box(2048, 2048, 2048),
                                 pack_box(-524288, -524288, -524288),
                                 pack_box(524287, 524287, 524287));
                1: apply_setting(8'($urandom_range(2, 4)),
                                 {4'b0, 60'($urandom) << 32 | $urandom},
                                 {4'b0, 60'($urandom) << 32 | $urandom},
                                 pack_box(-3000, -2500, -4000), pack_box(3500, 2000, 4096));
                // stride zero behaves as one; small box is inverted
                2: apply_setting(8'd0, pack_box(1000, 1000, 1000), pack_box(-1000, -1000, -1000),
                                 pack_box(-524288, -524288, -524288),
                                 pack_box(524287, 524287, 524287));
                3: apply_setting(8'd255, pack_box(-4096, -4096, -4096),
                                 pack_box(4096, 4096, 4096), pack_box(-524288, -524288, -524288),
                                 pack_box(524287, 524287, 524287));
                4: apply_setting(8'd2, pack_box(-100, -200, -300), pack_box(100, 200, 300),
                                 pack_box(0, 0, 0), pack_box(524287, 524287, 524287));
                default: apply_setting(8'd1, pack_box(-524288, -524288, -524288),
                                       pack_box(524287, 524287, 524287),
                                       pack_box(-524288, -524288, -524288),
                                       pack_box(524287, 524287, 524287));
            endcase
            no_idle = (ph == 2);
            for (int i = 0; i < n_per; i++) begin
                s = rand_sphere(ph == 5 || (ph == 1 && i < 20), (ph == 3) ? 300 : 8);
                send_sphere(s, i == n_per - 1);
            end
            drain_results();
        end
        no_idle = 0;

        $display("Covered %0d spheres, %0d segments, %0d saturating additions,",
                 item_count, segment_count, sat_count);
        $display("across strides 0, 1, 2-4, 255 with inverted, point and full-range boxes.");
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
